// File: rtl/core/renreg_pkg.sv
// Package for the renamed register file core: sizes, request and response layouts.
// Used by renamed_register_file_core; depends on nothing.
`default_nettype none

package renreg_pkg;

   localparam int NUM_REGS    = 32;
   localparam int TAG_COUNT   = 16;
   localparam int REG_IDX_W   = $clog2(NUM_REGS);
   localparam int TAG_W       = $clog2(TAG_COUNT);
   localparam int REG_FIELD_W = 5;
   localparam int CTAG_W      = 4;
   localparam int RTAG_W      = 5;
   localparam int DATA_W      = 32;
   localparam int REQ_BITS    = 65;
   localparam int RSP_BITS    = 143;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [RTAG_W-1:0] NO_TAG = '1;

   // first field in the lowest bits, so declared last
   typedef struct packed {
      logic [REQ_TDATA_W-REQ_BITS-1:0] pad;
      logic [REG_FIELD_W-1:0]          read_reg_b;
      logic [REG_FIELD_W-1:0]          read_reg_a;
      logic                            flush;
      logic signed [RTAG_W-1:0]        rename_tag;
      logic [REG_FIELD_W-1:0]          rename_reg;
      logic                            rename_valid;
      logic [CTAG_W-1:0]               commit_tag;
      logic signed [DATA_W-1:0]        commit_value;
      logic [REG_FIELD_W-1:0]          commit_reg;
      logic                            commit_is_store;
      logic                            commit_valid;
   } req_type;

   typedef struct packed {
      logic [RSP_TDATA_W-RSP_BITS-1:0] pad;
      logic [CTAG_W-1:0]               store_tag;
      logic signed [DATA_W-1:0]        store_data;
      logic signed [DATA_W-1:0]        store_passed_value;
      logic                            store_valid;
      logic signed [RTAG_W-1:0]        read_tag_b;
      logic signed [DATA_W-1:0]        read_value_b;
      logic signed [RTAG_W-1:0]        read_tag_a;
      logic signed [DATA_W-1:0]        read_value_a;
   } rsp_type;

   function automatic logic idx_ok(input logic [REG_FIELD_W-1:0] r);
      return (r != '0) && (32'(r) < NUM_REGS);
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/renamed_register_file_core.sv
// Renamed register file core: register values with a reorder-buffer tag per register.
// Depends on renreg_pkg.
// Input stage, then response register; one request per cycle sustained unless the
// output stalls, set by tag update and RAM ports (read at accept, write on update).
// Reset (synchronous, active high) empties the pipeline, marks every value as zero and
// every tag as no producer; no clearing pass is needed.
`default_nettype none

module renamed_register_file_core
   import renreg_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // commit_valid, commit_is_store, commit_reg, commit_value, commit_tag, rename_valid,
   // rename_reg, rename_tag, flush, read_reg_a, read_reg_b, zero pad
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // read_value_a, read_tag_a, read_value_b, read_tag_b, store_valid,
   // store_passed_value, store_data, store_tag, zero pad
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   req_type                    req;
   req_type                    s1_ff;
   logic                       s1_valid_ff;
   rsp_type                    rsp_ff;
   rsp_type                    rsp_in;
   logic                       rsp_valid_ff;
   logic                       advance;
   logic                       accept;

   logic [DATA_W-1:0]          mem_ab_ff [NUM_REGS];
   logic [DATA_W-1:0]          mem_c_ff  [NUM_REGS];
   logic [NUM_REGS-1:0]        written_ff;
   logic [DATA_W-1:0]          rd_a_ff, rd_b_ff, rd_c_ff;
   logic                       ok_a_ff, ok_b_ff, ok_c_ff;

   logic                       wr_en;
   logic [REG_IDX_W-1:0]       wr_addr;
   logic [REG_IDX_W-1:0]       ra_idx, rb_idx, rc_idx;

   logic [NUM_REGS-1:0]        tag_vld_ff, tag_vld_in;
   logic [TAG_W-1:0]           tag_ff [NUM_REGS];
   logic [TAG_W-1:0]           tag_in [NUM_REGS];
   logic                       rename_hit;
   logic                       rename_ok;
   logic [REG_IDX_W-1:0]       s1_ra, s1_rb, s1_cr, s1_rr;

   assign req        = req_type'(req_tdata);
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign s1_ra = s1_ff.read_reg_a[REG_IDX_W-1:0];
   assign s1_rb = s1_ff.read_reg_b[REG_IDX_W-1:0];
   assign s1_cr = s1_ff.commit_reg[REG_IDX_W-1:0];
   assign s1_rr = s1_ff.rename_reg[REG_IDX_W-1:0];

   assign wr_en   = advance && s1_ff.commit_valid && !s1_ff.commit_is_store
                    && idx_ok(s1_ff.commit_reg);
   assign wr_addr = s1_cr;
   assign ra_idx  = req.read_reg_a[REG_IDX_W-1:0];
   assign rb_idx  = req.read_reg_b[REG_IDX_W-1:0];
   assign rc_idx  = req.commit_reg[REG_IDX_W-1:0];

   // value RAMs: two copies, same writes
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ab_ff[wr_addr] <= s1_ff.commit_value;
         mem_c_ff[wr_addr]  <= s1_ff.commit_value;
      end
      if (accept) begin
         rd_a_ff <= mem_ab_ff[ra_idx];
         rd_b_ff <= mem_ab_ff[rb_idx];
         rd_c_ff <= mem_c_ff[rc_idx];
      end
   end

   // read data bypass flags for a write landing at the same edge
   logic byp_a_ff, byp_b_ff, byp_c_ff;
   logic [DATA_W-1:0] byp_val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
      if (accept) begin
         byp_a_ff   <= wr_en && (wr_addr == ra_idx);
         byp_b_ff   <= wr_en && (wr_addr == rb_idx);
         byp_c_ff   <= wr_en && (wr_addr == rc_idx);
         byp_val_ff <= s1_ff.commit_value;
         ok_a_ff    <= idx_ok(req.read_reg_a) && (written_ff[ra_idx] || (wr_en && wr_addr == ra_idx));
         ok_b_ff    <= idx_ok(req.read_reg_b) && (written_ff[rb_idx] || (wr_en && wr_addr == rb_idx));
         ok_c_ff    <= idx_ok(req.commit_reg) && (written_ff[rc_idx] || (wr_en && wr_addr == rc_idx));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
      if (accept) begin
         s1_ff <= req;
      end
   end

   // tag table update: commit clear, rename, flush
   assign rename_hit = s1_ff.rename_valid && idx_ok(s1_ff.rename_reg);
   assign rename_ok  = !s1_ff.rename_tag[RTAG_W-1]
                       && (32'(unsigned'(s1_ff.rename_tag)) < TAG_COUNT);

   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         tag_vld_in[i] = tag_vld_ff[i];
         tag_in[i]     = tag_ff[i];
         if (s1_ff.commit_valid && tag_vld_ff[i]
             && (32'(tag_ff[i]) == 32'(s1_ff.commit_tag))) begin
            tag_vld_in[i] = 1'b0;
         end
         if (rename_hit && (s1_rr == REG_IDX_W'(i))) begin
            tag_vld_in[i] = rename_ok;
            tag_in[i]     = s1_ff.rename_tag[TAG_W-1:0];
         end
         if (s1_ff.flush) begin
            tag_vld_in[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_vld_ff <= '0;
      end else if (advance) begin
         tag_vld_ff <= tag_vld_in;
      end
      if (advance) begin
         tag_ff <= tag_in;
      end
   end

   // response
   logic [DATA_W-1:0] val_a, val_b, val_c;
   logic              own_a, own_b;

   always_comb begin
      val_a = byp_a_ff ? byp_val_ff : rd_a_ff;
      val_b = byp_b_ff ? byp_val_ff : rd_b_ff;
      val_c = byp_c_ff ? byp_val_ff : rd_c_ff;
      own_a = s1_ff.commit_valid && !s1_ff.commit_is_store && idx_ok(s1_ff.commit_reg)
              && (s1_cr == s1_ra) && idx_ok(s1_ff.read_reg_a);
      own_b = s1_ff.commit_valid && !s1_ff.commit_is_store && idx_ok(s1_ff.commit_reg)
              && (s1_cr == s1_rb) && idx_ok(s1_ff.read_reg_b);

      rsp_in = '0;
      rsp_in.read_value_a = own_a ? s1_ff.commit_value : (ok_a_ff ? val_a : '0);
      rsp_in.read_value_b = own_b ? s1_ff.commit_value : (ok_b_ff ? val_b : '0);
      rsp_in.read_tag_a   = (idx_ok(s1_ff.read_reg_a) && tag_vld_in[s1_ra])
                            ? {{(RTAG_W-TAG_W){1'b0}}, tag_in[s1_ra]} : NO_TAG;
      rsp_in.read_tag_b   = (idx_ok(s1_ff.read_reg_b) && tag_vld_in[s1_rb])
                            ? {{(RTAG_W-TAG_W){1'b0}}, tag_in[s1_rb]} : NO_TAG;
      if (s1_ff.commit_valid && s1_ff.commit_is_store) begin
         rsp_in.store_valid        = 1'b1;
         rsp_in.store_passed_value = s1_ff.commit_value;
         rsp_in.store_data         = ok_c_ff ? val_c : '0;
         rsp_in.store_tag          = s1_ff.commit_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_ff);

   // register zero never carries a producer tag
   a_reg0_untagged: assert property (@(posedge clock) disable iff (reset)
      !tag_vld_ff[0])
      else $error("register zero holds a tag");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      advance && s1_ff.flush |=> tag_vld_ff == '0)
      else $error("tags survive a flush");

   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(advance))
      else $error("response raised without a request leaving the input stage");

endmodule

`default_nettype wire
